FILE: rtl/core/rpqs_pkg.sv
// ----------------------------------------------------------------------------
// rpqs_pkg
// Shared constants, types and helpers of the random pivot quicksort unit.
// ----------------------------------------------------------------------------
package rpqs_pkg;

    localparam int MAX_ELEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ELEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int CMP_W     = 11;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        t_addr hi;
        t_addr lo;
    } t_range;

    // one step of the 32-bit xorshift generator
    function automatic logic [DATA_W-1:0] xorshift32(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

FILE: rtl/core/random_pivot_quicksort_unit.sv
// ----------------------------------------------------------------------------
// random_pivot_quicksort_unit
// In-place quicksort (random pivot, Lomuto partition) over an element RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_stall, i_value, i_last): one signed value per
//    transaction is appended to the element RAM. A transaction with i_last set,
//    or the one that fills the RAM (MAX_ELEMS entries), starts the sort.
//  - While sorting and emitting, o_stall is high; no input is lost.
//  - Output channel (o_valid / i_stall): one transaction per stored value, in
//    ascending order. o_final_res marks the last one, which carries the number
//    of partition comparisons in o_comparisons (zero elsewhere).
//  - Config channel (i_cfg_valid / o_cfg_ready): pivot seed, always ready,
//    copied into the xorshift state when a sort starts. Reset value is 1.
// Sequence:
//  - Loading: one transaction per cycle.
//  - Each partition of a range: setup, mostly the bit-serial modulo that
//    picks the pivot, then per compared element a read, a compare and, if
//    needed, a swap (RAM with one read and one write port), then the final
//    pivot swap and the stack pushes.
//  - Output: each value is read, registered and held until not stalled; a
//    full set of random data spends most of its time in partition setup.
// Reset (synchronous, active low) empties the set and clears the control
// state; RAM contents are not cleared and are never read before written.
// A stalled output holds value and flags until taken.
// ----------------------------------------------------------------------------
module random_pivot_quicksort_unit
    import rpqs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_final_res,
    output logic [CMP_W-1:0]         o_comparisons,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    typedef enum logic [4:0] {
        ST_LOAD, ST_POP, ST_POPD, ST_MOD, ST_PIV0, ST_PIV1, ST_PIV2, ST_PIV3,
        ST_RDI, ST_CMP, ST_SWA, ST_SWB, ST_FIN, ST_FIN2, ST_FIN3,
        ST_PUSHR, ST_PUSHL, ST_OUTRD, ST_OUTLD, ST_OUTHOLD
    } t_state;

    // element RAM and range stack RAM, with registered read data
    logic [DATA_W-1:0] r_store [MAX_ELEMS];
    t_range            r_stack [MAX_ELEMS];
    logic [DATA_W-1:0] r_store_q;
    t_range            r_stack_q;

    logic              n_st_we;
    t_addr             n_st_waddr;
    logic [DATA_W-1:0] n_st_wdata;
    t_addr             n_st_raddr;
    logic              n_sk_we;
    t_addr             n_sk_waddr;
    t_range            n_sk_wdata;
    t_addr             n_sk_raddr;

    t_state            r_state;
    t_cnt              r_count;
    t_cnt              r_sp;
    logic [DATA_W-1:0] r_seed;
    logic [DATA_W-1:0] r_rand;
    logic [DATA_W-1:0] r_div;
    logic [ADDR_W:0]   r_rem;
    logic [ADDR_W:0]   r_len;
    logic [DIV_CNT_W-1:0] r_bit;
    t_addr             r_lo;
    t_addr             r_hi;
    t_addr             r_i;
    t_addr             r_m;
    t_addr             r_p;
    logic signed [DATA_W-1:0] r_pv;
    logic [DATA_W-1:0] r_ai;
    logic [DATA_W-1:0] r_am;
    logic [CMP_W-1:0]  r_cmp;
    t_cnt              r_k;
    logic              r_valid;
    logic [DATA_W-1:0] r_out;
    logic              r_final;
    logic [CMP_W-1:0]  r_out_cmp;

    logic              in_acc;
    t_cnt              n_cnt_inc;
    logic [DATA_W-1:0] rand_next;
    logic [ADDR_W+1:0] rem_shift;
    t_addr             m_inc;
    logic [ADDR_W:0]   m_plus1;
    logic              push_r;
    logic              push_l;
    t_cnt              k_inc;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_LOAD);
    assign in_acc      = i_valid && !o_stall;
    assign n_cnt_inc   = r_count + t_cnt'(1);
    assign rand_next   = xorshift32(r_rand);
    assign rem_shift   = {r_rem, r_div[DATA_W-1]};
    assign m_inc       = r_m + t_addr'(1);
    assign m_plus1     = {1'b0, r_m} + (ADDR_W+1)'(1);
    assign push_r      = m_plus1 < {1'b0, r_hi};
    assign push_l      = {1'b0, r_m} > ({1'b0, r_lo} + (ADDR_W+1)'(1));
    assign k_inc       = r_k + t_cnt'(1);

    assign o_valid        = r_valid;
    assign o_sorted_value = r_out;
    assign o_final_res    = r_final;
    assign o_comparisons  = r_out_cmp;

    // RAM port control
    always_comb begin
        n_st_we    = 1'b0;
        n_st_waddr = r_lo;
        n_st_wdata = r_ai;
        n_st_raddr = r_i;
        n_sk_we    = 1'b0;
        n_sk_waddr = r_sp[ADDR_W-1:0];
        n_sk_wdata = '{hi: r_hi, lo: m_plus1[ADDR_W-1:0]};
        n_sk_raddr = r_sp[ADDR_W-1:0] - t_addr'(1);
        case (r_state)
            ST_LOAD: begin
                n_st_we    = in_acc;
                n_st_waddr = r_count[ADDR_W-1:0];
                n_st_wdata = i_value;
                n_sk_we    = in_acc;
                n_sk_waddr = '0;
                n_sk_wdata = '{hi: r_count[ADDR_W-1:0], lo: '0};
            end
            ST_PIV0:  n_st_raddr = r_lo;
            ST_PIV1:  n_st_raddr = r_p;
            ST_PIV2: begin
                n_st_we    = 1'b1;
                n_st_waddr = r_lo;
                n_st_wdata = r_store_q;
            end
            ST_PIV3: begin
                n_st_we    = 1'b1;
                n_st_waddr = r_p;
                n_st_wdata = r_ai;
            end
            ST_RDI:   n_st_raddr = r_i;
            ST_CMP:   n_st_raddr = m_inc;
            ST_SWA: begin
                n_st_we    = 1'b1;
                n_st_waddr = r_m;
                n_st_wdata = r_ai;
            end
            ST_SWB: begin
                n_st_we    = 1'b1;
                n_st_waddr = r_i;
                n_st_wdata = r_am;
            end
            ST_FIN:   n_st_raddr = r_m;
            ST_FIN2: begin
                n_st_we    = 1'b1;
                n_st_waddr = r_lo;
                n_st_wdata = r_store_q;
            end
            ST_FIN3: begin
                n_st_we    = 1'b1;
                n_st_waddr = r_m;
                n_st_wdata = r_pv;
            end
            ST_PUSHR: n_sk_we = push_r && (r_sp < t_cnt'(MAX_ELEMS));
            ST_PUSHL: begin
                n_sk_we    = push_l && (r_sp < t_cnt'(MAX_ELEMS));
                n_sk_wdata = '{hi: r_m - t_addr'(1), lo: r_lo};
            end
            ST_OUTRD: n_st_raddr = r_k[ADDR_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_st_we) begin
            r_store[n_st_waddr] <= n_st_wdata;
        end
        r_store_q <= r_store[n_st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (n_sk_we) begin
            r_stack[n_sk_waddr] <= n_sk_wdata;
        end
        r_stack_q <= r_stack[n_sk_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_sp    <= '0;
            r_seed  <= 32'd1;
            r_rand  <= 32'd1;
            r_cmp   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_data;
            end
            case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        r_count <= n_cnt_inc;
                        if (i_last || n_cnt_inc == t_cnt'(MAX_ELEMS)) begin
                            r_rand <= r_seed;
                            r_cmp  <= '0;
                            r_k    <= '0;
                            if (n_cnt_inc >= t_cnt'(2)) begin
                                r_sp    <= t_cnt'(1);
                                r_state <= ST_POP;
                            end else begin
                                r_sp    <= '0;
                                r_state <= ST_OUTRD;
                            end
                        end
                    end
                end
                ST_POP: begin
                    r_sp    <= r_sp - t_cnt'(1);
                    r_state <= ST_POPD;
                end
                ST_POPD: begin
                    r_lo    <= r_stack_q.lo;
                    r_hi    <= r_stack_q.hi;
                    r_len   <= {1'b0, r_stack_q.hi} - {1'b0, r_stack_q.lo}
                               + (ADDR_W+1)'(1);
                    r_rand  <= rand_next;
                    r_div   <= rand_next;
                    r_rem   <= '0;
                    r_bit   <= '1;
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    // restoring remainder, one dividend bit per cycle
                    if (rem_shift >= {1'b0, r_len}) begin
                        r_rem <= (ADDR_W+1)'(rem_shift - {1'b0, r_len});
                    end else begin
                        r_rem <= rem_shift[ADDR_W:0];
                    end
                    r_div <= r_div << 1;
                    r_bit <= r_bit - DIV_CNT_W'(1);
                    if (r_bit == '0) begin
                        r_state <= ST_PIV0;
                    end
                end
                ST_PIV0: begin
                    r_p     <= r_lo + r_rem[ADDR_W-1:0];
                    r_state <= ST_PIV1;
                end
                ST_PIV1: begin
                    r_ai    <= r_store_q;
                    r_state <= ST_PIV2;
                end
                ST_PIV2: begin
                    r_pv    <= r_store_q;
                    r_state <= ST_PIV3;
                end
                ST_PIV3: begin
                    r_m     <= r_lo;
                    r_i     <= r_lo + t_addr'(1);
                    r_state <= ST_RDI;
                end
                ST_RDI: r_state <= ST_CMP;
                ST_CMP: begin
                    r_cmp <= r_cmp + CMP_W'(1);
                    r_ai  <= r_store_q;
                    if ($signed(r_store_q) < r_pv) begin
                        r_m <= m_inc;
                        if (m_inc != r_i) begin
                            r_state <= ST_SWA;
                        end else if (r_i == r_hi) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_i     <= r_i + t_addr'(1);
                            r_state <= ST_RDI;
                        end
                    end else if (r_i == r_hi) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_i     <= r_i + t_addr'(1);
                        r_state <= ST_RDI;
                    end
                end
                ST_SWA: begin
                    r_am    <= r_store_q;
                    r_state <= ST_SWB;
                end
                ST_SWB: begin
                    if (r_i == r_hi) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_i     <= r_i + t_addr'(1);
                        r_state <= ST_RDI;
                    end
                end
                ST_FIN:  r_state <= (r_m == r_lo) ? ST_PUSHR : ST_FIN2;
                ST_FIN2: r_state <= ST_FIN3;
                ST_FIN3: r_state <= ST_PUSHR;
                ST_PUSHR: begin
                    if (n_sk_we) begin
                        r_sp <= r_sp + t_cnt'(1);
                    end
                    r_state <= ST_PUSHL;
                end
                ST_PUSHL: begin
                    if (n_sk_we) begin
                        r_sp    <= r_sp + t_cnt'(1);
                        r_state <= ST_POP;
                    end else if (r_sp != '0) begin
                        r_state <= ST_POP;
                    end else begin
                        r_state <= ST_OUTRD;
                    end
                end
                ST_OUTRD: r_state <= ST_OUTLD;
                ST_OUTLD: begin
                    r_valid   <= 1'b1;
                    r_out     <= r_store_q;
                    r_final   <= (k_inc == r_count);
                    r_out_cmp <= (k_inc == r_count) ? r_cmp : '0;
                    r_state   <= ST_OUTHOLD;
                end
                ST_OUTHOLD: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        if (r_final) begin
                            r_count <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_k     <= k_inc;
                            r_state <= ST_OUTRD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

endmodule

FILE: rtl/core/rpqs_checker.sv
// ----------------------------------------------------------------------------
// rpqs_checker
// Port-level checks of the random pivot quicksort unit.
// ----------------------------------------------------------------------------
module rpqs_checker
    import rpqs_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [DATA_W-1:0] o_sorted_value,
    input logic                     o_final_res,
    input logic [CMP_W-1:0]         o_comparisons
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sorted_value)
                               && $stable(o_final_res))
        else $error("stalled result changed");

    // count only on the final result
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_res |-> o_comparisons == '0)
        else $error("nonzero comparison count on non-final result");

    // no input taken while results are pending
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while emitting");

    // reset clears the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind random_pivot_quicksort_unit rpqs_checker u_rpqs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sorted_value (o_sorted_value),
    .o_final_res    (o_final_res),
    .o_comparisons  (o_comparisons)
);
